### rtl/core/epoch_seconds_to_calendar_unit_assert.svh
// assertion macros for the calendar conversion rtl
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication on the clk / rst_n of the including module
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication with a fixed number of cycles between cause and effect
`define ESC_ASSERT_DLY(lbl, ante, cons, dly, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);
`else
`define ESC_ASSERT_IMP(lbl, ante, cons, msg)
`define ESC_ASSERT_DLY(lbl, ante, cons, dly, msg)
`endif
`endif

### rtl/core/esc_pkg.sv
// constants and helpers for the epoch seconds to calendar conversion
package esc_pkg;

    // pipeline depth from accepted transaction to result strobe
    localparam int LATENCY = 9;

    localparam logic [10:0] EPOCH_YEAR      = 11'd1970;
    localparam logic [16:0] HOURS_PER_CYCLE = 17'((365 * 3 + 366) * 24);
    localparam logic [13:0] HOURS_PER_YEAR  = 14'(365 * 24);
    localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
    localparam logic [5:0]  SIXTY           = 6'd60;

    // floor reciprocals, the estimate is at most one below the true quotient
    localparam int          SHIFT60  = 36;
    localparam logic [31:0] RECIP60  = 32'((64'd1 << SHIFT60) / 64'd60);
    localparam int          SHIFT24  = 24;
    localparam logic [19:0] RECIP24  = 20'((64'd1 << SHIFT24) / 64'd24);
    localparam int          SHIFTCYC = 32;
    localparam logic [16:0] RECIPCYC = 17'((64'd1 << SHIFTCYC) / 64'(HOURS_PER_CYCLE));

    // rounded-up reciprocal of 3, exact for dividends below 2^13
    localparam int          SHIFT3 = 13;
    localparam logic [11:0] RECIP3 = 12'(((64'd1 << SHIFT3) + 64'd2) / 64'd3);

    // zero-based day of year on which each month starts, common year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // years reached lie in 1970..2038, where the only century year is 2000
    function automatic logic is_leap(input logic [10:0] y);
        return (y[1:0] == 2'b00);
    endfunction

    // first day of a month, shifted by one after february in a leap year
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        base = MONTH_START[idx];
        if (leap && (idx >= 4'd2))
            return base + 9'd1;
        return base;
    endfunction

endpackage

### rtl/core/epoch_seconds_to_calendar_unit.sv
// epoch seconds to utc calendar date and time, nine-stage pipeline
//
// Usage:
//   Drive epoch_seconds and raise start for one cycle per transaction. A
//   transaction is taken at each rising edge with start high and busy low;
//   busy stays low, so one transaction can enter in every cycle.
//   When a transaction leaves stage i, done is high for exactly one cycle together with
//   year, month, day, hour, minute and second. Results leave in the order
//   the transactions came in, one per cycle at full rate.
//   The stages form the divider chain: two divides by 60 and the split by
//   24 hours and by four-year cycles each take a reciprocal multiply stage
//   and a correction stage; then come the year step, the divide of hours by
//   24 and the month lookup, one stage each.
//   The receiver cannot stall: done is a strobe and results are not held.
//   Reset (rst_n low, asynchronous) clears the valid bits of every stage,
//   so transactions in flight are dropped and no strobe follows.
`include "epoch_seconds_to_calendar_unit_assert.svh"

module epoch_seconds_to_calendar_unit
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] epoch_seconds,
    output logic        done,
    output logic [10:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    // valid bit per stage
    logic [LATENCY-1:0] valid_reg, valid_next;

    // stage a: first divide by 60 estimate
    logic [30:0] a_x_reg;
    logic [25:0] a_qe_reg, a_qe_next;
    logic [62:0] a_prod;

    // stage b: seconds and total minutes
    logic [5:0]  b_sec_reg, b_sec_next;
    logic [25:0] b_m_reg, b_m_next;
    logic [31:0] b_diff;
    logic        b_over;

    // stage c: second divide by 60 estimate
    logic [5:0]  c_sec_reg;
    logic [25:0] c_m_reg;
    logic [19:0] c_qe_reg, c_qe_next;
    logic [57:0] c_prod;

    // stage d: minutes and total hours
    logic [5:0]  d_sec_reg;
    logic [5:0]  d_min_reg, d_min_next;
    logic [19:0] d_h_reg, d_h_next;
    logic [26:0] d_diff;
    logic        d_over;

    // stage e: estimates for hours per day and hours per four-year cycle
    logic [5:0]  e_sec_reg, e_min_reg;
    logic [19:0] e_h_reg;
    logic [14:0] e_qe24_reg, e_qe24_next;
    logic [4:0]  e_qec_reg, e_qec_next;
    logic [39:0] e_prod24;
    logic [36:0] e_prodc;

    // stage f: hour of day, cycle count, hours into the cycle
    logic [5:0]  f_sec_reg, f_min_reg;
    logic [4:0]  f_hour_reg, f_hour_next;
    logic [4:0]  f_cyc_reg, f_cyc_next;
    logic [15:0] f_hc_reg, f_hc_next;
    logic [20:0] f_diff24, f_diffc;
    logic [5:0]  f_r24;
    logic [16:0] f_rc;
    logic        f_overc;

    // stage g: year and hours into the year
    logic [5:0]  g_sec_reg, g_min_reg;
    logic [4:0]  g_hour_reg;
    logic [10:0] g_year_reg, g_year_next;
    logic [13:0] g_hy_reg, g_hy_next;
    logic        g_leap_reg, g_leap_next;
    logic [15:0] g_t;
    logic [13:0] g_len;
    logic        g_stop;

    // stage h: zero-based day of year
    logic [5:0]  h_sec_reg, h_min_reg;
    logic [4:0]  h_hour_reg;
    logic [10:0] h_year_reg;
    logic        h_leap_reg;
    logic [8:0]  h_doy_reg, h_doy_next;
    logic [22:0] h_prod;

    // stage i: month and day, registered outputs
    logic [5:0]  i_sec_reg, i_min_reg;
    logic [4:0]  i_hour_reg;
    logic [10:0] i_year_reg;
    logic [3:0]  i_mon_reg, i_mon_next;
    logic [4:0]  i_day_reg, i_day_next;
    logic [3:0]  i_idx;
    logic [8:0]  i_off;

    // every cycle takes a new transaction
    assign busy       = 1'b0;
    assign valid_next = {valid_reg[LATENCY-2:0], start};

    // stage a
    always_comb
    begin
        a_prod    = 63'(epoch_seconds) * 63'(RECIP60);
        a_qe_next = a_prod[SHIFT60 +: 26];
    end

    // stage b: remainder below 120, one correction
    always_comb
    begin
        b_diff     = {1'b0, a_x_reg} - (32'(a_qe_reg) * 32'(SIXTY));
        b_over     = (b_diff[6:0] >= 7'(SIXTY));
        b_sec_next = b_over ? 6'(b_diff[6:0] - 7'(SIXTY)) : b_diff[5:0];
        b_m_next   = b_over ? a_qe_reg + 26'd1 : a_qe_reg;
    end

    // stage c
    always_comb
    begin
        c_prod    = 58'(b_m_reg) * 58'(RECIP60);
        c_qe_next = c_prod[SHIFT60 +: 20];
    end

    // stage d
    always_comb
    begin
        d_diff     = {1'b0, c_m_reg} - (27'(c_qe_reg) * 27'(SIXTY));
        d_over     = (d_diff[6:0] >= 7'(SIXTY));
        d_min_next = d_over ? 6'(d_diff[6:0] - 7'(SIXTY)) : d_diff[5:0];
        d_h_next   = d_over ? c_qe_reg + 20'd1 : c_qe_reg;
    end

    // stage e: two independent reciprocal multiplies
    always_comb
    begin
        e_prod24    = 40'(d_h_reg) * 40'(RECIP24);
        e_qe24_next = e_prod24[SHIFT24 +: 15];
        e_prodc     = 37'(d_h_reg) * 37'(RECIPCYC);
        e_qec_next  = e_prodc[SHIFTCYC +: 5];
    end

    // stage f: corrections for both divides
    always_comb
    begin
        f_diff24    = {1'b0, e_h_reg} - (21'(e_qe24_reg) * 21'(HOURS_PER_DAY));
        f_r24       = f_diff24[5:0];
        f_hour_next = (f_r24 >= 6'(HOURS_PER_DAY)) ? 5'(f_r24 - 6'(HOURS_PER_DAY))
                                                    : f_r24[4:0];
        f_diffc     = {1'b0, e_h_reg} - (21'(e_qec_reg) * 21'(HOURS_PER_CYCLE));
        f_rc        = f_diffc[16:0];
        f_overc     = (f_rc >= HOURS_PER_CYCLE);
        f_hc_next   = f_overc ? 16'(f_rc - HOURS_PER_CYCLE) : f_rc[15:0];
        f_cyc_next  = f_overc ? e_qec_reg + 5'd1 : e_qec_reg;
    end

    // stage g: step over up to three single years
    always_comb
    begin
        g_year_next = EPOCH_YEAR + (11'(f_cyc_reg) << 2);
        g_t         = f_hc_reg;
        g_stop      = 1'b0;
        g_len       = HOURS_PER_YEAR;
        for (int k = 0; k < 3; k++)
        begin
            g_len = HOURS_PER_YEAR + (is_leap(g_year_next) ? 14'(HOURS_PER_DAY) : 14'd0);
            if (!g_stop)
            begin
                if (g_t < 16'(g_len))
                begin
                    g_stop = 1'b1;
                end
                else
                begin
                    g_year_next = g_year_next + 11'd1;
                    g_t         = g_t - 16'(g_len);
                end
            end
        end
        g_hy_next   = g_t[13:0];
        g_leap_next = is_leap(g_year_next);
    end

    // stage h: hours / 24 as (hours / 8) / 3
    always_comb
    begin
        h_prod     = 23'(g_hy_reg[13:3]) * 23'(RECIP3);
        h_doy_next = h_prod[SHIFT3 +: 9];
    end

    // stage i: last month start not past the day of year
    always_comb
    begin
        i_idx = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (h_doy_reg >= month_start(4'(m), h_leap_reg))
                i_idx = 4'(m);
        end
        i_off      = h_doy_reg - month_start(i_idx, h_leap_reg);
        i_day_next = 5'(i_off + 9'd1);
        i_mon_next = i_idx + 4'd1;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_x_reg    <= epoch_seconds;
        a_qe_reg   <= a_qe_next;

        b_sec_reg  <= b_sec_next;
        b_m_reg    <= b_m_next;

        c_sec_reg  <= b_sec_reg;
        c_m_reg    <= b_m_reg;
        c_qe_reg   <= c_qe_next;

        d_sec_reg  <= c_sec_reg;
        d_min_reg  <= d_min_next;
        d_h_reg    <= d_h_next;

        e_sec_reg  <= d_sec_reg;
        e_min_reg  <= d_min_reg;
        e_h_reg    <= d_h_reg;
        e_qe24_reg <= e_qe24_next;
        e_qec_reg  <= e_qec_next;

        f_sec_reg  <= e_sec_reg;
        f_min_reg  <= e_min_reg;
        f_hour_reg <= f_hour_next;
        f_cyc_reg  <= f_cyc_next;
        f_hc_reg   <= f_hc_next;

        g_sec_reg  <= f_sec_reg;
        g_min_reg  <= f_min_reg;
        g_hour_reg <= f_hour_reg;
        g_year_reg <= g_year_next;
        g_hy_reg   <= g_hy_next;
        g_leap_reg <= g_leap_next;

        h_sec_reg  <= g_sec_reg;
        h_min_reg  <= g_min_reg;
        h_hour_reg <= g_hour_reg;
        h_year_reg <= g_year_reg;
        h_leap_reg <= g_leap_reg;
        h_doy_reg  <= h_doy_next;

        i_sec_reg  <= h_sec_reg;
        i_min_reg  <= h_min_reg;
        i_hour_reg <= h_hour_reg;
        i_year_reg <= h_year_reg;
        i_mon_reg  <= i_mon_next;
        i_day_reg  <= i_day_next;
    end

    // outputs
    assign done   = valid_reg[LATENCY-1];
    assign year   = i_year_reg;
    assign month  = i_mon_reg;
    assign day    = i_day_reg;
    assign hour   = i_hour_reg;
    assign minute = i_min_reg;
    assign second = i_sec_reg;

    // assertions
    `ESC_ASSERT_DLY(a_start_gives_done, start, done, LATENCY, "accepted transaction lost")
    `ESC_ASSERT_IMP(a_done_has_start, done, $past(start, LATENCY), "result without transaction")
    `ESC_ASSERT_IMP(a_fields_in_range, done,
        (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) &&
        (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59),
        "field out of range")
    `ESC_ASSERT_IMP(a_february_len, done && (month == 4'd2),
        day <= (is_leap(year) ? 5'd29 : 5'd28), "february day out of range")

endmodule
